[rtl/core/point_cloud_edge_classifier_defines.svh]
// ----------------------------------------------------------------------------
// point_cloud_edge_classifier_defines
// Assertion macros used by the checker file pcec_checker.
// ----------------------------------------------------------------------------
`ifndef POINT_CLOUD_EDGE_CLASSIFIER_DEFINES_SVH
`define POINT_CLOUD_EDGE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PCEC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define PCEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/core/pcec_pkg.sv]
// ----------------------------------------------------------------------------
// pcec_pkg
// Types and constants of the point cloud edge classifier.
// ----------------------------------------------------------------------------
package pcec_pkg;

	localparam int COORD_BITS    = 20;
	localparam int CAPACITY      = 256;
	localparam int IDX_W         = $clog2(CAPACITY);
	localparam int CNT_W         = IDX_W + 1;
	localparam int MAX_NB        = 32;
	localparam int NB_W          = $clog2(MAX_NB) + 1;
	localparam int NBI_W         = $clog2(MAX_NB);
	localparam int DIFF_W        = COORD_BITS + 1;
	localparam int DIST_W        = 2 * COORD_BITS + 2;
	localparam int DMIN_W        = 34;
	localparam int SUM_W         = COORD_BITS + NBI_W;
	localparam int MUL_A_W       = DMIN_W;
	localparam int MUL_B_W       = DIFF_W;
	localparam int PROD_W        = MUL_A_W + MUL_B_W;
	localparam int RATIO_W       = 16;
	localparam int K_W           = 6;
	localparam int CFG_W         = 16;

	localparam logic [DIST_W-1:0] NEAR_SKIP = DIST_W'(1000);
	localparam logic [DMIN_W-1:0] START_MIN = DMIN_W'(64'd10000000000);
	localparam logic [K_W-1:0]    K_RESET   = K_W'(30);
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(256);

	localparam logic [1:0] CMD_CLEAR    = 2'd0;
	localparam logic [1:0] CMD_APPEND   = 2'd1;
	localparam logic [1:0] CMD_CLASSIFY = 2'd2;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	localparam logic REG_K     = 1'b0;
	localparam logic REG_RATIO = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [1:0]       cmd;
		coord_t           point_x;
		coord_t           point_y;
		coord_t           point_z;
		logic [IDX_W-1:0] query_index;
	} in_item_t;

	typedef struct packed {
		logic   is_edge;
		logic   bad_index;
		coord_t edge_x;
		coord_t edge_y;
		coord_t edge_z;
	} out_item_t;

endpackage

[rtl/core/point_cloud_edge_classifier.sv]
// ----------------------------------------------------------------------------
// point_cloud_edge_classifier
// Stores 3-D points and classifies one of them as edge or not from the
// centroid of its K nearest stored neighbours.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | in_item (cmd, point, query_index)
// out     | output    | out_valid/out_ready | out_item (is_edge, bad_index, point)
// cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// Clear and append leave the block idle. Classify visits every stored
// point (one shared multiplier does the three squares), then each kept
// neighbour, summing it unless it lies within NEAR_SKIP, and ends with the
// three 25-step serial divides and the ratio compare.
// Reset empties the store; no clearing pass is needed.
// in_ready is high only while idle; a result waits in the output register
// until taken, and a new item is accepted meanwhile.
// ----------------------------------------------------------------------------
module point_cloud_edge_classifier (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pcec_pkg::in_item_t        in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output pcec_pkg::out_item_t       out_item,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [pcec_pkg::CFG_W-1:0] cfg_wdata
);
	import pcec_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_QLAT, S_SRD, S_DIFF, S_MX, S_MY, S_MZ, S_ACC, S_INS,
		S_RRD, S_RADD, S_DLD, S_DRUN, S_DST, S_RMUL, S_CMP, S_EMIT
	} state_t;

	typedef logic [3*COORD_BITS-1:0] word_t;

	state_t state_q;

	logic [K_W-1:0]     k_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [CNT_W-1:0]   count_q;

	word_t mem [CAPACITY];
	word_t rd_q;
	logic [IDX_W-1:0] raddr;

	coord_t p_q [3];
	coord_t c_q [3];
	logic [DIFF_W-1:0] ad_q [3];
	logic signed [SUM_W-1:0] sum_q [3];

	logic [IDX_W-1:0]   i_q;
	logic [NB_W-1:0]    kk_q;
	logic [NB_W-1:0]    n_q;
	logic [NB_W-1:0]    j_q;
	logic [NB_W-1:0]    num_q;
	logic [DIST_W-1:0]  bd_q [MAX_NB];
	logic [IDX_W-1:0]   bi_q [MAX_NB];
	logic [DMIN_W-1:0]  dmin_q;
	logic               fin_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod_q;
	logic [DIST_W-1:0]  acc_q;
	logic [DIST_W-1:0]  dist_q;

	logic [1:0]         axis_q;
	logic [SUM_W-1:0]   dv_q;
	logic [NBI_W-1:0]   rem_q;
	logic [4:0]         dcnt_q;

	out_item_t res_q;
	out_item_t out_q;
	logic      out_valid_q;

	logic [MAX_NB-1:0] le;
	logic [MAX_NB-1:0] ins;
	logic [MAX_NB-1:0] shf;
	logic [NB_W-1:0]   kk_sat;
	logic [NBI_W:0]    dtmp;
	coord_t            rd_c [3];
	coord_t            src [3];
	logic signed [DIFF_W-1:0] dsig [3];
	logic [SUM_W-1:0]  sum_mag;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign rd_c[0] = rd_q[3*COORD_BITS-1:2*COORD_BITS];
	assign rd_c[1] = rd_q[2*COORD_BITS-1:COORD_BITS];
	assign rd_c[2] = rd_q[COORD_BITS-1:0];

	always_comb begin
		unique case (state_q)
			S_IDLE:  raddr = in_item.query_index;
			S_SRD:   raddr = i_q;
			S_RRD:   raddr = bi_q[j_q[NBI_W-1:0]];
			default: raddr = i_q;
		endcase
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_item.cmd == CMD_APPEND
			&& count_q < CNT_W'(CAPACITY)) begin
			mem[count_q[IDX_W-1:0]] <= {in_item.point_x, in_item.point_y, in_item.point_z};
		end
		rd_q <= mem[raddr];
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			src[a]  = fin_q ? c_q[a] : rd_c[a];
			dsig[a] = DIFF_W'(src[a]) - DIFF_W'(p_q[a]);
		end
	end

	// sorted insertion cells: each cell keeps, takes the new distance, or
	// takes its left neighbour
	always_comb begin
		for (int j = 0; j < MAX_NB; j++) begin
			le[j] = (NB_W'(j) < n_q) && (bd_q[j] <= dist_q);
		end
		for (int j = 0; j < MAX_NB; j++) begin
			if (j == 0) begin
				ins[j] = (NB_W'(j) < kk_q) && !le[j];
				shf[j] = 1'b0;
			end else begin
				ins[j] = (NB_W'(j) < kk_q) && !le[j] && le[j-1];
				shf[j] = (NB_W'(j) < kk_q) && !le[j-1];
			end
		end
	end

	always_comb begin
		kk_sat = (k_q > K_W'(MAX_NB)) ? NB_W'(MAX_NB) : NB_W'(k_q);
		if (count_q < CNT_W'(kk_sat)) begin
			kk_sat = NB_W'(count_q);
		end
	end

	assign dtmp    = {rem_q, dv_q[SUM_W-1]};
	assign sum_mag = sum_q[axis_q][SUM_W-1] ? SUM_W'(-sum_q[axis_q]) : SUM_W'(sum_q[axis_q]);

	always_comb begin
		unique case (state_q)
			S_MX:    begin mul_a = MUL_A_W'(ad_q[0]); mul_b = ad_q[0]; end
			S_MY:    begin mul_a = MUL_A_W'(ad_q[1]); mul_b = ad_q[1]; end
			S_MZ:    begin mul_a = MUL_A_W'(ad_q[2]); mul_b = ad_q[2]; end
			S_RMUL:  begin mul_a = dmin_q; mul_b = MUL_B_W'(ratio_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				res_q <= '{is_edge: 1'b0, bad_index: 1'b1, default: '0};
			end
			S_QLAT: begin
				for (int a = 0; a < 3; a++) begin
					p_q[a]   <= rd_c[a];
					sum_q[a] <= '0;
				end
				kk_q   <= kk_sat;
				n_q    <= '0;
				i_q    <= '0;
				fin_q  <= 1'b0;
				dmin_q <= START_MIN;
				num_q  <= '0;
			end
			S_DIFF: begin
				for (int a = 0; a < 3; a++) begin
					ad_q[a] <= dsig[a][DIFF_W-1] ? DIFF_W'(-dsig[a]) : DIFF_W'(dsig[a]);
				end
			end
			S_MY:  acc_q <= prod_q[DIST_W-1:0];
			S_MZ:  acc_q <= acc_q + prod_q[DIST_W-1:0];
			S_ACC: dist_q <= acc_q + prod_q[DIST_W-1:0];
			S_INS: begin
				if (ins[0]) begin
					bd_q[0] <= dist_q;
					bi_q[0] <= i_q;
				end
				for (int j = 1; j < MAX_NB; j++) begin
					if (ins[j]) begin
						bd_q[j] <= dist_q;
						bi_q[j] <= i_q;
					end else if (shf[j]) begin
						bd_q[j] <= bd_q[j-1];
						bi_q[j] <= bi_q[j-1];
					end
				end
				if (|ins && n_q < kk_q) begin
					n_q <= n_q + 1'b1;
				end
				i_q <= i_q + 1'b1;
				j_q <= '0;
			end
			S_RRD: begin
				if (j_q == n_q) begin
					axis_q <= '0;
					if (num_q == '0) begin
						for (int a = 0; a < 3; a++) c_q[a] <= '0;
						fin_q <= 1'b1;
					end
				end else if (bd_q[j_q[NBI_W-1:0]] <= NEAR_SKIP) begin
					j_q <= j_q + 1'b1;
				end
			end
			S_RADD: begin
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= sum_q[a] + SUM_W'(rd_c[a]);
				end
				num_q <= num_q + 1'b1;
				if (bd_q[j_q[NBI_W-1:0]] < DIST_W'(dmin_q)) begin
					dmin_q <= bd_q[j_q[NBI_W-1:0]][DMIN_W-1:0];
				end
				j_q <= j_q + 1'b1;
			end
			S_DLD: begin
				dv_q   <= sum_mag;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			S_DRUN: begin
				// restoring divide, one quotient bit per cycle
				if (dtmp >= (NBI_W+1)'(num_q)) begin
					rem_q <= NBI_W'(dtmp - (NBI_W+1)'(num_q));
					dv_q  <= {dv_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= dtmp[NBI_W-1:0];
					dv_q  <= {dv_q[SUM_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_DST: begin
				c_q[axis_q] <= sum_q[axis_q][SUM_W-1] ? COORD_BITS'(-dv_q) : COORD_BITS'(dv_q);
				axis_q <= axis_q + 1'b1;
				if (axis_q == 2'd2) begin
					fin_q <= 1'b1;
				end
			end
			S_CMP: begin
				res_q.is_edge   <= PROD_W'({dist_q, 8'd0}) > prod_q;
				res_q.bad_index <= 1'b0;
				res_q.edge_x    <= p_q[0];
				res_q.edge_y    <= p_q[1];
				res_q.edge_z    <= p_q[2];
			end
			default: ;
		endcase
	end

	// sequencer, configuration, count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= K_RESET;
			ratio_q     <= RATIO_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_K:     k_q     <= cfg_wdata[K_W-1:0];
					REG_RATIO: ratio_q <= cfg_wdata[RATIO_W-1:0];
					default:   ;
				endcase
			end
			// in S_EMIT the output register is handled below
			if (out_ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_item.cmd == CMD_CLEAR) begin
							count_q <= '0;
						end else if (in_item.cmd == CMD_APPEND) begin
							if (count_q < CNT_W'(CAPACITY)) count_q <= count_q + 1'b1;
						end else if (in_item.cmd == CMD_CLASSIFY) begin
							if (CNT_W'(in_item.query_index) >= count_q) state_q <= S_EMIT;
							else state_q <= S_QLAT;
						end
					end
				end
				S_QLAT: state_q <= S_SRD;
				S_SRD:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_MX;
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_MZ;
				S_MZ:   state_q <= S_ACC;
				S_ACC:  state_q <= fin_q ? S_RMUL : S_INS;
				S_INS: begin
					if (CNT_W'(i_q) + 1'b1 == count_q) state_q <= S_RRD;
					else state_q <= S_SRD;
				end
				S_RRD: begin
					if (j_q == n_q) state_q <= (num_q == '0) ? S_DIFF : S_DLD;
					else if (bd_q[j_q[NBI_W-1:0]] > NEAR_SKIP) state_q <= S_RADD;
				end
				S_RADD: state_q <= S_RRD;
				S_DLD:  state_q <= S_DRUN;
				S_DRUN: if (dcnt_q == 5'(SUM_W - 1)) state_q <= S_DST;
				S_DST:  state_q <= (axis_q == 2'd2) ? S_DIFF : S_DLD;
				S_RMUL: state_q <= S_CMP;
				S_CMP:  state_q <= S_EMIT;
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/pcec_checker.sv]
// ----------------------------------------------------------------------------
// pcec_checker
// Port-level checks of the point cloud edge classifier.
// ----------------------------------------------------------------------------
`include "point_cloud_edge_classifier_defines.svh"

module pcec_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input pcec_pkg::in_item_t        in_item,
	input logic                      out_valid,
	input logic                      out_ready,
	input pcec_pkg::out_item_t       out_item
);
	import pcec_pkg::*;

	// a stalled item holds
	`PCEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "out item dropped or changed while stalled")

	// a bad index carries no classification or point
	`PCEC_ASSERT_NOW(a_bad_clean, out_valid && out_item.bad_index, !out_item.is_edge && out_item.edge_x == '0 && out_item.edge_y == '0 && out_item.edge_z == '0, "bad index item has nonzero fields")

	// a classify leaves the block busy in the cycle after it is taken
	`PCEC_ASSERT_NEXT(a_cls_busy, in_valid && in_ready && in_item.cmd == CMD_CLASSIFY, !in_ready, "ready right after classify")

	// clear and append give no result and leave the block ready
	`PCEC_ASSERT_NEXT(a_store_ready, in_valid && in_ready && (in_item.cmd == CMD_CLEAR || in_item.cmd == CMD_APPEND), in_ready, "store command left the block busy")

endmodule

bind point_cloud_edge_classifier pcec_checker u_pcec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_cloud_edge_classifier. Random point sets are
// loaded and classified under several k / ratio settings; every result is
// checked field by field against an in-bench nearest-neighbour predictor.
// ----------------------------------------------------------------------------
module tb;
	import pcec_pkg::*;

	localparam int WDOG_LIMIT = 40000;
	localparam int N_ITEMS    = 1600;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      cfg_we;
	logic      cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	point_cloud_edge_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	longint    st_x[CAPACITY];
	longint    st_y[CAPACITY];
	longint    st_z[CAPACITY];
	int        pt_count;
	int        k_set;
	int        ratio_set;

	in_item_t  pending_items[$];
	out_item_t expected_class[$];

	int        n_items, n_classified, n_edges, n_bad, errors;
	int        in_gap, rdy_gap, idle_cycles;
	bit        steady;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic longint sq3(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz);
		return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) + (az - bz) * (az - bz);
	endfunction

	function automatic out_item_t classify_point(int q);
		out_item_t r;
		longint    px, py, pz, d, sx, sy, sz, num, dmin, dc;
		longint    best_d[MAX_NB];
		int        best_i[MAX_NB];
		int        kk, n, p, last;
		r = '0;
		if (q >= pt_count) begin
			r.bad_index = 1'b1;
			return r;
		end
		px = st_x[q]; py = st_y[q]; pz = st_z[q];
		kk = k_set;
		if (kk > MAX_NB) kk = MAX_NB;
		if (kk > pt_count) kk = pt_count;
		n = 0;
		// sorted insertion, ties keep the lower index ahead
		for (int i = 0; i < pt_count; i++) begin
			d = sq3(px, py, pz, st_x[i], st_y[i], st_z[i]);
			p = 0;
			while (p < n && best_d[p] <= d) p++;
			if (p < kk) begin
				last = (n < kk) ? n : kk - 1;
				for (int j = last; j > p; j--) begin
					best_d[j] = best_d[j-1];
					best_i[j] = best_i[j-1];
				end
				best_d[p] = d;
				best_i[p] = i;
				if (n < kk) n++;
			end
		end
		sx = 0; sy = 0; sz = 0; num = 0;
		dmin = 64'd10000000000;
		for (int j = 0; j < n; j++) begin
			if (best_d[j] > 1000) begin
				sx += st_x[best_i[j]];
				sy += st_y[best_i[j]];
				sz += st_z[best_i[j]];
				num++;
				if (best_d[j] < dmin) dmin = best_d[j];
			end
		end
		if (num > 0) begin
			sx = sx / num; sy = sy / num; sz = sz / num;
		end
		dc = sq3(sx, sy, sz, px, py, pz);
		r.is_edge = (dc * 256) > (longint'(ratio_set) * dmin);
		r.edge_x  = coord_t'(px);
		r.edge_y  = coord_t'(py);
		r.edge_z  = coord_t'(pz);
		return r;
	endfunction

	task automatic predict(in_item_t it);
		out_item_t r;
		case (it.cmd)
			CMD_CLEAR: pt_count = 0;
			CMD_APPEND: begin
				if (pt_count < CAPACITY) begin
					st_x[pt_count] = longint'(it.point_x);
					st_y[pt_count] = longint'(it.point_y);
					st_z[pt_count] = longint'(it.point_z);
					pt_count++;
				end
			end
			CMD_CLASSIFY: begin
				r = classify_point(int'(it.query_index));
				expected_class = {expected_class, r};
				n_classified++;
				if (r.bad_index) n_bad++;
				if (r.is_edge) n_edges++;
			end
			default: ;
		endcase
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		logic busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			in_gap = 0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				predict(in_item);
				busy = 1'b0;
			end
			if (!busy) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_items.size() > 0) begin
					in_item <= pending_items.pop_front();
					busy = 1'b1;
					in_gap = pick_gap();
				end
			end
			in_valid <= busy;
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rdy_gap = 0;
		end else if (rdy_gap > 0) begin
			out_ready <= 1'b0;
			rdy_gap--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) rdy_gap = pick_gap();
		end
	end

	// result checker
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_class.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, out_item);
				errors++;
			end else begin
				e = expected_class.pop_front();
				if (out_item.is_edge !== e.is_edge) begin
					$display("%0t: is_edge expected %0d actual %0d", $time, e.is_edge,
						out_item.is_edge);
					errors++;
				end
				if (out_item.bad_index !== e.bad_index) begin
					$display("%0t: bad_index expected %0d actual %0d", $time, e.bad_index,
						out_item.bad_index);
					errors++;
				end
				if (out_item.edge_x !== e.edge_x) begin
					$display("%0t: edge_x expected %0d actual %0d", $time, e.edge_x,
						out_item.edge_x);
					errors++;
				end
				if (out_item.edge_y !== e.edge_y) begin
					$display("%0t: edge_y expected %0d actual %0d", $time, e.edge_y,
						out_item.edge_y);
					errors++;
				end
				if (out_item.edge_z !== e.edge_z) begin
					$display("%0t: edge_z expected %0d actual %0d", $time, e.edge_z,
						out_item.edge_z);
					errors++;
				end
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, expected_class.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic add_item(logic [1:0] cmd, longint x, longint y, longint z, int q);
		in_item_t it;
		it.cmd         = cmd;
		it.point_x     = coord_t'(x);
		it.point_y     = coord_t'(y);
		it.point_z     = coord_t'(z);
		it.query_index = IDX_W'(q);
		pending_items = {pending_items, it};
		if (cmd != CMD_UNUSED) n_items++;
	endtask

	// wait until everything queued has gone through and all results are back
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_class.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		if (idx == REG_K) k_set = val & 6'h3f;
		else ratio_set = val & 16'hffff;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic longint rand_coord();
		return longint'(coord_t'($urandom));
	endfunction

	task automatic add_cluster_point(longint cx, longint cy, longint cz, int spread);
		if (spread == 0)
			add_item(CMD_APPEND, rand_coord(), rand_coord(), rand_coord(), 0);
		else
			add_item(CMD_APPEND, cx + $urandom_range(0, 2 * spread) - spread,
				cy + $urandom_range(0, 2 * spread) - spread,
				cz + $urandom_range(0, 2 * spread) - spread, 0);
	endtask

	initial begin
		int     npts, ncls, sel, spread, kv, rv;
		longint cx, cy, cz;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		pt_count  = 0;
		k_set     = 30;
		ratio_set = 256;
		steady    = 1'b0;
		n_items = 0; n_classified = 0; n_edges = 0; n_bad = 0; errors = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty store, extremes, near duplicates, unused command
		add_item(CMD_CLASSIFY, 0, 0, 0, 0);
		add_item(CMD_CLASSIFY, 0, 0, 0, 255);
		add_item(CMD_APPEND, -524288, -524288, -524288, 0);
		add_item(CMD_APPEND, 524287, 524287, 524287, 0);
		add_item(CMD_APPEND, 0, 0, 0, 0);
		add_item(CMD_APPEND, 10, -10, 5, 0);
		add_item(CMD_APPEND, 524287, -524288, 0, 0);
		add_item(CMD_UNUSED, 1, 2, 3, 1);
		for (int i = 0; i < 5; i++) add_item(CMD_CLASSIFY, 0, 0, 0, i);
		add_item(CMD_CLASSIFY, 0, 0, 0, 5);
		add_item(CMD_CLEAR, 0, 0, 0, 0);
		add_item(CMD_CLASSIFY, 0, 0, 0, 0);
		add_item(CMD_APPEND, 7, 7, 7, 0);
		add_item(CMD_CLASSIFY, 0, 0, 0, 0);
		drain();

		// extremes of both registers on a small cluster
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_K, (ph == 0) ? 0 : (ph == 1) ? 1 : (ph == 2) ? 63 : 32);
			write_reg(REG_RATIO, (ph[0]) ? 65535 : 0);
			add_item(CMD_CLEAR, 0, 0, 0, 0);
			for (int i = 0; i < 12; i++) add_cluster_point(100, -200, 300, 60);
			for (int i = 0; i < 12; i++) add_item(CMD_CLASSIFY, 0, 0, 0, i);
			drain();
		end

		// full store: every index bit, append past capacity
		write_reg(REG_K, 32);
		write_reg(REG_RATIO, 256);
		add_item(CMD_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < CAPACITY + 1; i++) add_cluster_point(0, 0, 0, (i % 3) * 3000);
		add_item(CMD_CLASSIFY, 0, 0, 0, 255);
		add_item(CMD_CLASSIFY, 0, 0, 0, 8'h55);
		add_item(CMD_CLASSIFY, 0, 0, 0, 8'haa);
		add_item(CMD_CLASSIFY, 0, 0, 0, 0);
		for (int i = 0; i < 4; i++) add_item(CMD_CLASSIFY, 0, 0, 0, $urandom_range(0, 255));
		drain();

		// random phases
		while (n_items < N_ITEMS) begin
			steady = ($urandom_range(0, 5) == 0);
			sel = $urandom_range(0, 7);
			kv = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 63 : (sel == 3) ? 32 :
				(sel == 4) ? 30 : $urandom_range(0, 63);
			sel = $urandom_range(0, 6);
			rv = (sel == 0) ? 0 : (sel == 1) ? 65535 : (sel == 2) ? 256 :
				(sel == 3) ? 512 : (sel == 4) ? $urandom_range(0, 1024) : $urandom_range(0, 65535);
			write_reg(REG_K, kv);
			write_reg(REG_RATIO, rv);
			add_item(CMD_CLEAR, 0, 0, 0, 0);
			sel  = $urandom_range(0, 19);
			npts = (sel == 0) ? 1 : (sel == 1) ? $urandom_range(40, 80) : $urandom_range(2, 24);
			cx = rand_coord(); cy = rand_coord(); cz = rand_coord();
			sel = $urandom_range(0, 3);
			spread = (sel == 0) ? 0 : (sel == 1) ? 20 : (sel == 2) ? 300 : 3000;
			for (int i = 0; i < npts; i++) add_cluster_point(cx, cy, cz, spread);
			ncls = $urandom_range(5, 20);
			for (int i = 0; i < ncls; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 5)
					add_item(CMD_UNUSED, rand_coord(), rand_coord(), rand_coord(),
						$urandom_range(0, 255));
				else if (sel < 15)
					add_item(CMD_CLASSIFY, 0, 0, 0, $urandom_range(npts + 1, 255));
				else if (sel < 22)
					add_cluster_point(cx, cy, cz, spread);
				else
					add_item(CMD_CLASSIFY, 0, 0, 0, $urandom_range(0, npts - 1));
			end
			drain();
		end

		repeat (100) @(posedge clk);
		$display("Ran %0d items: %0d classified, %0d edge, %0d bad index.", n_items,
			n_classified, n_edges, n_bad);
		$display("Settings swept over k 0..63 and ratio 0..65535, store from empty to full.");
		if (errors == 0 && expected_class.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
